>>> rtl/atsp_pkg.sv
package atsp_pkg;

  // Problem size and field widths.
  localparam int MAX_VERTICES   = 16;
  localparam int WEIGHT_BITS    = 16;
  localparam int VTX_BITS       = $clog2(MAX_VERTICES);
  localparam int CNT_BITS       = $clog2(MAX_VERTICES + 1);
  localparam int COST_BITS      = 20;
  localparam int CFG_BITS       = 5;
  localparam int EDGE_ADDR_BITS = 2 * VTX_BITS;
  localparam int EDGE_DEPTH     = MAX_VERTICES * MAX_VERTICES;
  localparam int EDGE_BITS      = WEIGHT_BITS + 1;

  localparam logic [CFG_BITS-1:0] VCOUNT_RESET = CFG_BITS'(MAX_VERTICES);

  // Operation codes carried in the input tuser bit.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Input word layout, lowest bit first.
  localparam int IN_FROM_LSB    = 0;
  localparam int IN_TO_LSB      = 4;
  localparam int IN_WEIGHT_LSB  = 8;
  localparam int IN_PRESENT_BIT = 24;
  localparam int IN_START_LSB   = 25;
  localparam int IN_DATA_BITS   = 32;

  // Output word layout, lowest bit first.
  localparam int OUT_COST_LSB   = 0;
  localparam int OUT_POS_LSB    = 20;
  localparam int OUT_VTX_LSB    = 25;
  localparam int OUT_USED_BITS  = 29;
  localparam int OUT_DATA_BITS  = 32;

  // Configuration port.
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic REG_VCOUNT  = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_edge;
    logic init_search;
    logic scan;
    logic close_rd;
    logic advance;
    logic skip;
    logic close_chk;
    logic retreat;
    logic emit_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic depth_zero;
    logic depth_full;
    logic cand_found;
    logic edge_present;
    logic no_start;
    logic emit_last;
    logic out_free;
  } sts_t;

  // Vertex count in use: zero counts as one, large values are capped.
  function automatic logic [CNT_BITS-1:0] active_count(input logic [CFG_BITS-1:0] vc);
    logic [CNT_BITS-1:0] res;
    if (vc == '0) begin
      res = CNT_BITS'(1);
    end else if (vc > CFG_BITS'(MAX_VERTICES)) begin
      res = CNT_BITS'(MAX_VERTICES);
    end else begin
      res = vc[CNT_BITS-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/atsp_ctrl.sv
module atsp_ctrl
  import atsp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic in_op_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_STEP  = 5'b00010,
    ST_PROBE = 5'b00100,
    ST_CLOSE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OP_LOAD) begin
            cmd_o.load_edge = 1'b1;
          end else begin
            cmd_o.init_search = 1'b1;
            state_d = sts_i.no_start ? ST_EMIT : ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (sts_i.depth_zero) begin
          state_d = ST_EMIT;
        end else if (sts_i.depth_full) begin
          cmd_o.close_rd = 1'b1;
          state_d = ST_CLOSE;
        end else if (sts_i.cand_found) begin
          cmd_o.scan = 1'b1;
          state_d = ST_PROBE;
        end else begin
          cmd_o.retreat = 1'b1;
        end
      end
      ST_PROBE: begin
        if (sts_i.edge_present) begin
          cmd_o.advance = 1'b1;
        end else begin
          cmd_o.skip = 1'b1;
        end
        state_d = ST_STEP;
      end
      ST_CLOSE: begin
        cmd_o.close_chk = 1'b1;
        cmd_o.retreat   = 1'b1;
        state_d = ST_STEP;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/atsp_dp.sv
module atsp_dp
  import atsp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [CNT_BITS-1:0]    count_i,
  input  logic [VTX_BITS-1:0]    from_i,
  input  logic [VTX_BITS-1:0]    to_i,
  input  logic [WEIGHT_BITS-1:0] weight_i,
  input  logic                   present_i,
  input  logic [VTX_BITS-1:0]    start_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   out_found_o,
  output logic [COST_BITS-1:0]   out_cost_o,
  output logic [CNT_BITS-1:0]    out_pos_o,
  output logic [VTX_BITS-1:0]    out_vertex_o,
  output logic                   out_last_o
);

  // Edge store: present bit above the weight.
  logic [EDGE_BITS-1:0] edge_mem [EDGE_DEPTH];
  logic [EDGE_BITS-1:0] rd_q;
  logic [EDGE_ADDR_BITS-1:0] rd_addr;

  logic [MAX_VERTICES-1:0] visited_q;
  logic [VTX_BITS-1:0]     route_q [MAX_VERTICES];
  logic [VTX_BITS-1:0]     best_q  [MAX_VERTICES];
  logic [CNT_BITS-1:0]     cand_q  [MAX_VERTICES];
  logic [COST_BITS-1:0]    cost_q  [MAX_VERTICES];
  logic [CNT_BITS-1:0]     depth_q;
  logic [VTX_BITS-1:0]     start_q;
  logic [VTX_BITS-1:0]     sel_q;
  logic                    found_q;
  logic [COST_BITS-1:0]    best_cost_q;
  logic [CNT_BITS-1:0]     pos_q;

  logic                  out_valid_q;
  logic                  out_found_q;
  logic [COST_BITS-1:0]  out_cost_q;
  logic [CNT_BITS-1:0]   out_pos_q;
  logic [VTX_BITS-1:0]   out_vertex_q;
  logic                  out_last_q;

  logic [CNT_BITS-1:0]    depth_m1;
  logic [VTX_BITS-1:0]    top_idx;
  logic [VTX_BITS-1:0]    cur;
  logic [CNT_BITS-1:0]    cand_cur;
  logic [COST_BITS-1:0]   cost_cur;
  logic [COST_BITS-1:0]   cost_next;
  logic [MAX_VERTICES-1:0] avail;
  logic                   cand_found;
  logic [VTX_BITS-1:0]    cand_idx;
  logic                   better;
  logic                   emit_last;
  logic [VTX_BITS-1:0]    emit_vertex;

  assign depth_m1  = depth_q - CNT_BITS'(1);
  assign top_idx   = depth_m1[VTX_BITS-1:0];
  assign cur       = route_q[top_idx];
  assign cand_cur  = cand_q[top_idx];
  assign cost_cur  = cost_q[top_idx];
  assign cost_next = cost_cur + COST_BITS'(rd_q[WEIGHT_BITS-1:0]);
  assign better    = rd_q[WEIGHT_BITS] && (!found_q || (cost_next < best_cost_q));

  // Lowest unvisited vertex at or above the next candidate of the top frame.
  always_comb begin
    cand_found = 1'b0;
    cand_idx   = '0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      avail[j] = !visited_q[j] && (CNT_BITS'(j) >= cand_cur) && (CNT_BITS'(j) < count_i);
    end
    for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
      if (avail[j]) begin
        cand_found = 1'b1;
        cand_idx   = VTX_BITS'(j);
      end
    end
  end

  assign rd_addr = cmd_i.close_rd ? {cur, start_q} : {cur, cand_idx};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_edge) begin
      edge_mem[{from_i, to_i}] <= {present_i, weight_i};
    end
    if (cmd_i.scan || cmd_i.close_rd) begin
      rd_q <= edge_mem[rd_addr];
    end
  end

  assign emit_last   = !found_q || (pos_q == count_i);
  assign emit_vertex = (found_q && (pos_q < count_i)) ? best_q[pos_q[VTX_BITS-1:0]] : start_q;

  // Search control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      depth_q   <= '0;
      found_q   <= 1'b0;
      pos_q     <= '0;
    end else begin
      if (cmd_i.init_search) begin
        visited_q <= MAX_VERTICES'(1) << start_i;
        depth_q   <= sts_o.no_start ? CNT_BITS'(0) : CNT_BITS'(1);
        found_q   <= 1'b0;
        pos_q     <= '0;
      end else begin
        if (cmd_i.advance) begin
          visited_q[sel_q] <= 1'b1;
          depth_q <= depth_q + CNT_BITS'(1);
        end
        if (cmd_i.retreat) begin
          if (depth_q > CNT_BITS'(1)) begin
            visited_q[cur] <= 1'b0;
          end
          depth_q <= depth_m1;
        end
        if (cmd_i.close_chk && better) begin
          found_q <= 1'b1;
        end
        if (cmd_i.emit_load) begin
          pos_q <= pos_q + CNT_BITS'(1);
        end
      end
    end
  end

  // Route, candidate and cost frames, and the best tour.
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_search) begin
      start_q    <= start_i;
      route_q[0] <= start_i;
      cand_q[0]  <= '0;
      cost_q[0]  <= '0;
    end
    if (cmd_i.scan) begin
      sel_q <= cand_idx;
    end
    if (cmd_i.advance || cmd_i.skip) begin
      cand_q[top_idx] <= {1'b0, sel_q} + CNT_BITS'(1);
    end
    if (cmd_i.advance) begin
      route_q[depth_q[VTX_BITS-1:0]] <= sel_q;
      cand_q[depth_q[VTX_BITS-1:0]]  <= '0;
      cost_q[depth_q[VTX_BITS-1:0]]  <= cost_next;
    end
    if (cmd_i.close_chk && better) begin
      best_cost_q <= cost_next;
      best_q      <= route_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_found_q  <= found_q;
      out_cost_q   <= found_q ? best_cost_q : '0;
      out_pos_q    <= pos_q;
      out_vertex_q <= emit_vertex;
      out_last_q   <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_found_o  = out_found_q;
  assign out_cost_o   = out_cost_q;
  assign out_pos_o    = out_pos_q;
  assign out_vertex_o = out_vertex_q;
  assign out_last_o   = out_last_q;

  assign sts_o.depth_zero   = (depth_q == '0);
  assign sts_o.depth_full   = (depth_q >= count_i);
  assign sts_o.cand_found   = cand_found;
  assign sts_o.edge_present = rd_q[WEIGHT_BITS];
  assign sts_o.no_start     = ({1'b0, start_i} >= count_i);
  assign sts_o.emit_last    = emit_last;
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

endmodule

>>> rtl/atsp_exhaustive_search.sv
// Exact solver for the asymmetric travelling salesman problem by depth-first
// backtracking. An input word with tuser low loads one directed edge (weight
// and present bit) in the idle state. An input word with tuser high starts a
// search from the given vertex: the block walks every Hamiltonian path in
// ascending neighbour order, keeps each strictly cheaper closed tour and
// then sends it out one vertex per word, ending with the start vertex again
// (tlast on the final word, tuser set when a tour was found). When no tour
// exists, a single word carrying the start vertex is sent with tuser clear.
// The search runs on a shared edge store with a registered read port: each
// probed neighbour passes through the step and probe states, each closing
// of a full path through the step and close states, each step back through
// the step state alone, and visited vertices are skipped without a store
// read. Search time grows with the number of partial paths, roughly
// factorially in vertex_count; no new word is accepted from the start of a
// search until its last result word is in the output register. Unless the
// output side stalls, the tour goes out one word per cycle, vertex count in
// use plus one words. The user writes vertex_count through the APB port at
// byte address 0 only while idle; the block itself does not enforce this.
module atsp_exhaustive_search
  import atsp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // APB configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  // Input stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // from_vertex[3:0], to_vertex[7:4], edge_weight[23:8], edge_present[24],
  // start_vertex[28:25], zeros above
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // op[0]
  input  logic                     s_axis_tuser,
  // Output stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // best_cost[19:0], position[24:20], tour_vertex[28:25], zeros above
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  // tour_found[0]
  output logic                     m_axis_tuser,
  // last
  output logic                     m_axis_tlast
);

  logic [CFG_BITS-1:0] vcount_q;
  logic [CNT_BITS-1:0] count;
  logic                cfg_wr;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  logic                  out_found;
  logic [COST_BITS-1:0]  out_cost;
  logic [CNT_BITS-1:0]   out_pos;
  logic [VTX_BITS-1:0]   out_vertex;

  // The register is written on the access cycle of a write transfer.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VCOUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RESET;
    end else if (cfg_wr) begin
      vcount_q <= pwdata[CFG_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_VCOUNT) ? APB_DATA_BITS'(vcount_q) : '0;
  assign count  = active_count(vcount_q);

  atsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (in_ready),
    .in_op_i    (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  atsp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .count_i      (count),
    .from_i       (s_axis_tdata[IN_FROM_LSB +: VTX_BITS]),
    .to_i         (s_axis_tdata[IN_TO_LSB +: VTX_BITS]),
    .weight_i     (s_axis_tdata[IN_WEIGHT_LSB +: WEIGHT_BITS]),
    .present_i    (s_axis_tdata[IN_PRESENT_BIT]),
    .start_i      (s_axis_tdata[IN_START_LSB +: VTX_BITS]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_found_o  (out_found),
    .out_cost_o   (out_cost),
    .out_pos_o    (out_pos),
    .out_vertex_o (out_vertex),
    .out_last_o   (m_axis_tlast)
  );

  assign s_axis_tready = in_ready;
  assign m_axis_tuser  = out_found;
  assign m_axis_tdata  = {(OUT_DATA_BITS - OUT_USED_BITS)'(0), out_vertex, out_pos, out_cost};

endmodule

>>> test/atsp_exhaustive_search_tb.sv
`timescale 1ns / 100ps

module atsp_exhaustive_search_tb;
  import atsp_pkg::*;

  // A dense seven vertex graph is the slowest search that the random part
  // asks for, and the limit allows a wide margin over it with nothing moving
  // on either stream.
  localparam int WATCHDOG_LIMIT = 250000;
  // Input words for the whole run; the random phases stop once it is reached.
  localparam int ITEM_TARGET    = 280;
  // A load leaves no result behind, so the block is given time to finish it
  // before the register is written.
  localparam int SETTLE_CYCLES  = 8;
  localparam logic [APB_ADDR_BITS-1:0] VCOUNT_ADDR = {REG_VCOUNT, 2'b00};
  localparam longint unsigned COST_CAP = (64'd1 << COST_BITS) - 64'd1;

  // One word of a reported tour, as it should leave the block.
  typedef struct packed {
    logic                 found;
    logic [COST_BITS-1:0] cost;
    logic [CNT_BITS-1:0]  pos;
    logic [VTX_BITS-1:0]  vtx;
    logic                 last;
  } tour_word_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  // from_vertex, to_vertex, edge_weight, edge_present, start_vertex, zeros
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;
  // op
  logic                     s_axis_tuser;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  // best_cost, position, tour_vertex, zeros
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  // tour_found
  logic                     m_axis_tuser;
  logic                     m_axis_tlast;

  // Our own copy of the edge store and the register. written_tab remembers
  // which entries have been loaded, so that no search ever reads an entry
  // whose contents are still undefined.
  logic [WEIGHT_BITS-1:0] weight_tab [MAX_VERTICES][MAX_VERTICES];
  bit                     link_tab [MAX_VERTICES][MAX_VERTICES];
  bit                     written_tab [MAX_VERTICES][MAX_VERTICES];
  logic [CFG_BITS-1:0]    vcount_reg;

  // Outcome of the most recent tour planning.
  bit                     tour_exists;
  longint unsigned        tour_cost;
  int                     best_path [MAX_VERTICES];

  tour_word_t tour_words_due [$];

  int  loads_sent;
  int  searches_sent;
  int  words_checked;
  int  mismatches;
  int  stuck_cycles;
  bit  sender_calm;

  atsp_exhaustive_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // A register value of zero still means one vertex, and anything above the
  // maximum is clipped to it.
  function automatic int vertices_in_use(input logic [CFG_BITS-1:0] value);
    if (value == '0) return 1;
    if (value > CFG_BITS'(MAX_VERTICES)) return MAX_VERTICES;
    return int'(value);
  endfunction

  // Depth-first walk over every Hamiltonian path from start, neighbours in
  // ascending order. Only a strictly cheaper closed tour replaces the one
  // held, so among equal costs the first one found wins.
  function automatic void plan_tour(input int start, input int n);
    int                    path [MAX_VERTICES];
    int                    cand [MAX_VERTICES];
    bit [MAX_VERTICES-1:0] seen;
    int                    depth;
    int                    cur;
    int                    i;
    int                    v;
    longint unsigned       run_cost;
    longint unsigned       total;
    bit                    back;
    tour_exists = 1'b0;
    tour_cost = '1;
    run_cost = 0;
    seen = '0;
    seen[start] = 1'b1;
    path[0] = start;
    cand[0] = 0;
    depth = 1;
    while (depth > 0) begin
      cur = path[depth-1];
      back = 1'b1;
      if (depth >= n) begin
        // Full path: try to close it back to the start.
        if (link_tab[cur][start]) begin
          total = run_cost + weight_tab[cur][start];
          if (total < tour_cost) begin
            tour_cost = total;
            tour_exists = 1'b1;
            for (int k = 0; k < MAX_VERTICES; k++) best_path[k] = path[k];
          end
        end
      end else begin
        i = cand[depth-1];
        while (i < n && (seen[i] || !link_tab[cur][i])) i++;
        if (i < n) begin
          cand[depth-1] = i + 1;
          seen[i] = 1'b1;
          path[depth] = i;
          run_cost += weight_tab[cur][i];
          cand[depth] = 0;
          depth++;
          back = 1'b0;
        end
      end
      if (back) begin
        depth--;
        if (depth > 0) begin
          v = path[depth];
          seen[v] = 1'b0;
          run_cost -= weight_tab[path[depth-1]][v];
        end
      end
    end
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Weights lean towards the ends of the range and towards small values,
  // the latter so that equal-cost tours turn up often.
  function automatic logic [WEIGHT_BITS-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return WEIGHT_BITS'($urandom_range(0, 15));
    return WEIGHT_BITS'($urandom);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // Present one word on the input stream, hold it until it is taken, then
  // bring our copy of the block up to date. A search leaves its tour words
  // in the queue of words still due.
  task automatic send_word(input logic op, input logic [VTX_BITS-1:0] from_v,
                           input logic [VTX_BITS-1:0] to_v,
                           input logic [WEIGHT_BITS-1:0] weight, input logic present,
                           input logic [VTX_BITS-1:0] start_v);
    int                      gap;
    int                      n;
    logic [IN_DATA_BITS-1:0] word;
    logic [COST_BITS-1:0]    cost;
    tour_word_t              w;
    gap = sender_calm ? 0 : idle_length();
    word = '0;
    word[IN_FROM_LSB +: VTX_BITS] = from_v;
    word[IN_TO_LSB +: VTX_BITS] = to_v;
    word[IN_WEIGHT_LSB +: WEIGHT_BITS] = weight;
    word[IN_PRESENT_BIT] = present;
    word[IN_START_LSB +: VTX_BITS] = start_v;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      s_axis_tdata = $urandom;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = word;
    s_axis_tuser = op;
    do @(posedge clk_i); while (!s_axis_tready);

    if (op == OP_LOAD) begin
      weight_tab[from_v][to_v] = weight;
      link_tab[from_v][to_v] = present;
      written_tab[from_v][to_v] = 1'b1;
      loads_sent++;
    end else begin
      searches_sent++;
      n = vertices_in_use(vcount_reg);
      if (int'(start_v) < n) plan_tour(int'(start_v), n);
      else tour_exists = 1'b0;
      if (!tour_exists) begin
        w = '{found: 1'b0, cost: '0, pos: '0, vtx: start_v, last: 1'b1};
        tour_words_due = {tour_words_due, w};
      end else begin
        cost = (tour_cost > COST_CAP) ? COST_BITS'(COST_CAP) : COST_BITS'(tour_cost);
        for (int k = 0; k <= n; k++) begin
          w.found = 1'b1;
          w.cost = cost;
          w.pos = CNT_BITS'(k);
          w.vtx = (k < n) ? VTX_BITS'(best_path[k]) : start_v;
          w.last = (k == n);
          tour_words_due = {tour_words_due, w};
        end
      end
    end
  endtask

  // The start field is ignored on a load, so it carries noise.
  task automatic load_edge(input int from_v, input int to_v,
                           input logic [WEIGHT_BITS-1:0] weight, input logic present);
    send_word(OP_LOAD, VTX_BITS'(from_v), VTX_BITS'(to_v), weight, present,
              VTX_BITS'($urandom));
  endtask

  // Before a search, every edge that it may read is loaded if it never was:
  // the self edge of the start when one vertex is in use, otherwise every
  // edge between two distinct vertices in use. The edge fields of the search
  // word itself carry noise.
  task automatic search_from(input int start_v);
    int n;
    n = vertices_in_use(vcount_reg);
    if (start_v < n) begin
      for (int f = 0; f < n; f++) begin
        for (int t = 0; t < n; t++) begin
          if ((n == 1 || f != t) && !written_tab[f][t]) load_edge(f, t, pick_weight(), 1'b0);
        end
      end
    end
    send_word(OP_SEARCH, VTX_BITS'($urandom), VTX_BITS'($urandom), WEIGHT_BITS'($urandom),
              1'($urandom), VTX_BITS'(start_v));
  endtask

  // Stop sending, let every due tour word arrive and give a trailing load
  // time to land.
  task automatic wait_until_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (tour_words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the vertex count through the APB port and read it straight back.
  task automatic write_vertex_count(input logic [CFG_BITS-1:0] value);
    wait_until_idle();
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = VCOUNT_ADDR;
    pwdata = APB_DATA_BITS'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    vcount_reg = value;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("vertex_count read back", APB_DATA_BITS'(value), prdata);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // One vertex in use: the only tour is the self edge of vertex 0. A start
  // at or beyond the count finds nothing, and a count of zero acts as one.
  task automatic test_single_vertex();
    write_vertex_count(CFG_BITS'(1));
    load_edge(0, 0, '1, 1'b1);
    search_from(0);
    search_from(5);
    search_from(MAX_VERTICES - 1);
    load_edge(0, 0, 16'h1234, 1'b0);
    search_from(0);
    write_vertex_count('0);
    load_edge(0, 0, '0, 1'b1);
    search_from(0);
  endtask

  // Four vertices, every edge of equal weight: all tours tie, so the first
  // one in ascending order must be the one reported. Then one heavy edge and
  // one missing edge change the answer, and a start equal to the count finds
  // nothing.
  task automatic test_small_graph();
    write_vertex_count(CFG_BITS'(4));
    for (int f = 0; f < 4; f++) begin
      for (int t = 0; t < 4; t++) begin
        if (f != t) load_edge(f, t, 16'd5, 1'b1);
      end
    end
    search_from(0);
    load_edge(1, 2, '1, 1'b1);
    load_edge(3, 0, '0, 1'b0);
    search_from(1);
    search_from(3);
    search_from(4);
  endtask

  // Sixteen vertices, reached with the largest register value and again with
  // sixteen itself. A ring of maximum-weight edges with a few chords keeps
  // the walk short while the tour cost comes close to the 20-bit limit.
  // Breaking the ring afterwards leaves no tour at all.
  task automatic test_full_size();
    write_vertex_count('1);
    for (int v = 0; v < MAX_VERTICES; v++) load_edge(v, (v + 1) % MAX_VERTICES, '1, 1'b1);
    load_edge(3, 5, '0, 1'b1);
    load_edge(9, 7, '0, 1'b1);
    load_edge(14, 0, 16'd1, 1'b1);
    load_edge(6, 2, '0, 1'b1);
    search_from(0);
    search_from(MAX_VERTICES - 1);
    write_vertex_count(CFG_BITS'(MAX_VERTICES));
    search_from(8);
    load_edge(MAX_VERTICES - 1, 0, '0, 1'b0);
    search_from(8);
  endtask

  // Short phases of random graphs at up to seven vertices, each with a fresh
  // register value and edge density, until the run has sent its share of
  // words. Most words load edges between vertices in use; some load edges
  // anywhere, and searches start mostly inside the graph but now and then at
  // any vertex.
  task automatic test_random_graphs();
    int                  phase_len;
    int                  density;
    int                  r;
    int                  n;
    logic [CFG_BITS-1:0] vc;
    while (loads_sent + searches_sent < ITEM_TARGET) begin
      vc = CFG_BITS'($urandom_range(0, 7));
      write_vertex_count(vc);
      n = vertices_in_use(vc);
      density = $urandom_range(30, 95);
      sender_calm = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(6, 12);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          load_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_weight(),
                    $urandom_range(0, 99) < density);
        end else if (r < 82) begin
          load_edge($urandom_range(0, MAX_VERTICES - 1), $urandom_range(0, MAX_VERTICES - 1),
                    pick_weight(), 1'($urandom_range(0, 1)));
        end else if (r < 96) begin
          search_from($urandom_range(0, n - 1));
        end else begin
          search_from($urandom_range(0, MAX_VERTICES - 1));
        end
      end
    end
    sender_calm = 1'b0;
  endtask

  // Output side: bursts of readiness broken by stalls of random length, and
  // now and then a long stretch with no stall at all.
  initial begin : result_sink
    int  run_len;
    bit  calm;
    m_axis_tready = 1'b0;
    forever begin
      calm = ($urandom_range(0, 3) == 0);
      run_len = calm ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (run_len) begin
        @(negedge clk_i);
        m_axis_tready = 1'b1;
      end
      if (!calm) begin
        run_len = idle_length();
        repeat (run_len) begin
          @(negedge clk_i);
          m_axis_tready = 1'b0;
        end
      end
    end
  end

  // Every word taken from the output is held against the oldest one due.
  always @(posedge clk_i) begin : tour_check
    tour_word_t due;
    if (m_axis_tvalid && m_axis_tready) begin
      if (tour_words_due.size() == 0) begin
        mismatches++;
        $display("%0t: tour word with none due, expected nothing got tdata %h tuser %b tlast %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        due = tour_words_due.pop_front();
        check_field("tour_found", 32'(due.found), 32'(m_axis_tuser));
        check_field("best_cost", 32'(due.cost), 32'(m_axis_tdata[OUT_COST_LSB +: COST_BITS]));
        check_field("position", 32'(due.pos), 32'(m_axis_tdata[OUT_POS_LSB +: CNT_BITS]));
        check_field("tour_vertex", 32'(due.vtx), 32'(m_axis_tdata[OUT_VTX_LSB +: VTX_BITS]));
        check_field("last", 32'(due.last), 32'(m_axis_tlast));
        check_field("tdata padding", 32'd0,
                    32'(m_axis_tdata[OUT_DATA_BITS-1:OUT_USED_BITS]));
        words_checked++;
      end
    end
  end

  // The run is abandoned if no word moves on either stream for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_LOAD;
    vcount_reg = VCOUNT_RESET;
    sender_calm = 1'b0;
    loads_sent = 0;
    searches_sent = 0;
    words_checked = 0;
    mismatches = 0;
    stuck_cycles = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_vertex();
    test_small_graph();
    test_full_size();
    test_random_graphs();

    // Drain, then watch a little longer for any word that should not come.
    wait_until_idle();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d edge loads and %0d searches at vertex counts from one to sixteen",
             loads_sent, searches_sent);
    $display("(register values 0 and 31 included); %0d tour words checked, %0d mismatches.",
             words_checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
